>>> rtl/sfrc_pkg.sv
`timescale 1ns / 1ps

package sfrc_pkg;

    // Sync pair and header layout
    localparam logic [7:0] SYNC_A   = 8'hAA;
    localparam logic [7:0] SYNC_B   = 8'h55;
    localparam logic [2:0] POS_VER  = 3'd2;
    localparam logic [2:0] POS_ADDR = 3'd3;
    localparam logic [2:0] POS_LEN  = 3'd4;
    localparam logic [2:0] POS_CMD  = 3'd5;
    localparam logic [2:0] POS_SEQ  = 3'd6;
    localparam logic [2:0] HDR_FULL = 3'd7;

    // CRC16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_NODE  = 2'd0;
    localparam logic [1:0] REG_BCAST = 2'd1;
    localparam logic [1:0] REG_VER   = 2'd2;

    // Queue between parser and frame emitter
    localparam int QDEPTH = 4;
    localparam int QPW    = 2;
    localparam int QCW    = 3;

    localparam int TDATA_W = 40;

    typedef enum logic [1:0] {
        K_DATA,
        K_COMMIT,
        K_ABORT
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [7:0] seq;
        logic [7:0] len;
    } t_qent;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/sfrc_front.sv
`timescale 1ns / 1ps

module sfrc_front #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic [7:0]    i_node,
    input  logic [7:0]    i_bcast,
    input  logic [7:0]    i_ver,
    input  logic          i_full,
    output logic          o_push,
    output sfrc_pkg::t_qent o_ent
);

    localparam int         CW       = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_LEN  = 8'(MAX_PAYLOAD);
    localparam logic [2:0] HDR_FULL = sfrc_pkg::HDR_FULL;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CRC_HDR,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [7:0]      r_hdr [0:6];
    logic [7:0]      n_hdr [0:6];
    logic [2:0]      r_idx, n_idx;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_lo, n_lo;
    logic [2:0]      r_ci, n_ci;

    logic            accept;
    logic [7:0]      hdr_next [0:6];
    logic [2:0]      idx_next;
    logic            start;

    // Header realignment for one incoming byte
    always_comb begin
        logic [7:0] cand [0:6];
        logic [2:0] wr_pos;
        logic [2:0] cnt;
        logic       found;
        logic [2:0] at;
        logic [3:0] sh;
        cand   = r_hdr;
        wr_pos = (r_idx == HDR_FULL) ? 3'd0 : r_idx;
        cand[wr_pos] = i_byte;
        cnt    = wr_pos + 3'd1;
        found  = 1'b0;
        at     = 3'd0;
        sh     = 4'd0;
        hdr_next = cand;
        idx_next = cnt;
        start    = 1'b0;
        if (cnt == 3'd2) begin
            if (!(cand[0] == sfrc_pkg::SYNC_A && cand[1] == sfrc_pkg::SYNC_B)) begin
                hdr_next[0] = cand[1];
                idx_next    = 3'd1;
            end
        end else if (cnt == HDR_FULL) begin
            if (cand[sfrc_pkg::POS_LEN] > MAX_LEN) begin
                // drop the first sync byte, look for a later sync pair
                for (int j = 2; j <= 5; j++) begin
                    if (!found && cand[j] == sfrc_pkg::SYNC_A
                        && cand[j+1] == sfrc_pkg::SYNC_B) begin
                        found = 1'b1;
                        at    = 3'(j);
                    end
                end
                if (found) begin
                    for (int j = 0; j < 7; j++) begin
                        sh = {1'b0, at} + 4'(j);
                        if (sh <= 4'd6) begin
                            hdr_next[j] = cand[sh[2:0]];
                        end
                    end
                    idx_next = HDR_FULL - at;
                end else begin
                    hdr_next[0] = cand[6];
                    idx_next    = 3'd1;
                end
            end else begin
                start = 1'b1;
            end
        end
    end

    assign o_ready = !i_full && (r_phase == PH_HEADER || r_phase == PH_PAYLOAD
                                 || r_phase == PH_CRC_LO || r_phase == PH_CRC_HI);
    assign accept  = i_valid && o_ready;

    always_comb begin
        logic [CW-1:0] cnt_inc;
        logic [15:0]   got;
        logic          good;
        logic          mine;
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        n_lo    = r_lo;
        n_ci    = r_ci;
        cnt_inc = r_cnt + 1'b1;
        got     = {i_byte, r_lo};
        good    = (r_hdr[sfrc_pkg::POS_VER] == i_ver) && (got == r_crc);
        mine    = (r_hdr[sfrc_pkg::POS_ADDR] == i_node)
               || (r_hdr[sfrc_pkg::POS_ADDR] == i_bcast);
        o_push  = 1'b0;
        o_ent.kind = sfrc_pkg::K_DATA;
        o_ent.data = i_byte;
        o_ent.addr = r_hdr[sfrc_pkg::POS_ADDR];
        o_ent.cmd  = r_hdr[sfrc_pkg::POS_CMD];
        o_ent.seq  = r_hdr[sfrc_pkg::POS_SEQ];
        o_ent.len  = r_hdr[sfrc_pkg::POS_LEN];
        case (r_phase)
            PH_HEADER: begin
                if (accept) begin
                    n_hdr = hdr_next;
                    n_idx = idx_next;
                    if (start) begin
                        n_phase = PH_CRC_HDR;
                        n_crc   = sfrc_pkg::CRC_INIT;
                        n_ci    = 3'd0;
                    end
                end
            end
            PH_CRC_HDR: begin
                // one header byte per cycle, version through sequence
                n_crc = sfrc_pkg::crc16_byte(r_crc, r_hdr[3'(r_ci + sfrc_pkg::POS_VER)]);
                n_ci  = r_ci + 3'd1;
                if (r_ci == 3'd4) begin
                    n_cnt   = '0;
                    n_phase = (r_hdr[sfrc_pkg::POS_LEN] != 8'd0) ? PH_PAYLOAD : PH_CRC_LO;
                end
            end
            PH_PAYLOAD: begin
                if (accept) begin
                    o_push = 1'b1;
                    n_crc  = sfrc_pkg::crc16_byte(r_crc, i_byte);
                    n_cnt  = cnt_inc;
                    if (8'(cnt_inc) >= r_hdr[sfrc_pkg::POS_LEN]) begin
                        n_phase = PH_CRC_LO;
                    end
                end
            end
            PH_CRC_LO: begin
                if (accept) begin
                    n_lo    = i_byte;
                    n_phase = PH_CRC_HI;
                end
            end
            PH_CRC_HI: begin
                if (accept) begin
                    o_push     = 1'b1;
                    o_ent.kind = (good && mine) ? sfrc_pkg::K_COMMIT : sfrc_pkg::K_ABORT;
                    n_phase    = PH_HEADER;
                    n_idx      = 3'd0;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_idx   <= 3'd0;
            r_cnt   <= '0;
            r_crc   <= sfrc_pkg::CRC_INIT;
            r_lo    <= 8'd0;
            r_ci    <= 3'd0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            r_lo    <= n_lo;
            r_ci    <= n_ci;
        end
        r_hdr <= n_hdr;
    end

    a_hdr_pass_on_full_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CRC_HDR) |-> (r_idx == HDR_FULL && r_hdr[sfrc_pkg::POS_LEN] <= MAX_LEN))
        else $error("header CRC pass without a complete, legal header");

endmodule

>>> rtl/sfrc_fifo.sv
`timescale 1ns / 1ps

module sfrc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sfrc_pkg::t_qent i_ent,
    output logic            o_full,
    output logic            o_valid,
    output sfrc_pkg::t_qent o_ent,
    input  logic            i_pop
);

    sfrc_pkg::t_qent               r_mem [0:sfrc_pkg::QDEPTH-1];
    logic [sfrc_pkg::QPW-1:0]      r_wp;
    logic [sfrc_pkg::QPW-1:0]      r_rp;
    logic [sfrc_pkg::QCW-1:0]      r_cnt;

    assign o_full  = (r_cnt == sfrc_pkg::QCW'(sfrc_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("request popped from an empty queue");

endmodule

>>> rtl/sfrc_back.sv
`timescale 1ns / 1ps

module sfrc_back #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  sfrc_pkg::t_qent             i_q_ent,
    output logic                        o_q_pop,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [sfrc_pkg::TDATA_W-1:0] o_m_tdata,
    output logic                        o_m_tuser,
    output logic                        o_m_tlast
);

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } t_state;

    t_state                      r_state;
    logic [AW-1:0]               r_wptr;
    logic [CW-1:0]               r_k;
    logic [7:0]                  r_addr, r_cmd, r_seq, r_len;
    logic [7:0]                  r_mem [0:MAX_PAYLOAD-1];
    logic [7:0]                  r_rd;
    logic                        r_ov;
    logic [sfrc_pkg::TDATA_W-1:0] r_odata;
    logic                        r_opresent;
    logic                        r_olast;

    logic       out_free;
    logic [7:0] nres;
    logic       last;
    logic [7:0] pbyte;

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !r_ov || i_m_tready;
    assign nres     = (r_len == 8'd0) ? 8'd1 : r_len;
    assign last     = ((8'(r_k) + 8'd1) == nres);
    assign pbyte    = (r_len != 8'd0) ? r_rd : 8'd0;

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_opresent;
    assign o_m_tlast  = r_olast;

    // payload store: written from the queue, read at the emit index
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_ent.kind == sfrc_pkg::K_DATA) begin
            r_mem[r_wptr] <= i_q_ent.data;
        end
        r_rd <= r_mem[r_k[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wptr  <= '0;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_SEND && out_free) begin
                r_ov       <= 1'b1;
                r_odata    <= {2'b00, pbyte, r_len[5:0], r_seq, r_cmd, r_addr};
                r_opresent <= (r_len != 8'd0);
                r_olast    <= last;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        case (i_q_ent.kind)
                            sfrc_pkg::K_DATA: begin
                                r_wptr <= r_wptr + 1'b1;
                            end
                            sfrc_pkg::K_COMMIT: begin
                                r_wptr  <= '0;
                                r_k     <= '0;
                                r_addr  <= i_q_ent.addr;
                                r_cmd   <= i_q_ent.cmd;
                                r_seq   <= i_q_ent.seq;
                                r_len   <= i_q_ent.len;
                                r_state <= S_READ;
                            end
                            sfrc_pkg::K_ABORT: begin
                                r_wptr <= '0;
                            end
                            default: begin
                                r_wptr <= '0;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    if (out_free) begin
                        if (last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_wptr_clear_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_wptr == '0))
        else $error("payload write pointer not cleared during frame drain");

    a_empty_frame_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> o_m_tlast)
        else $error("empty-frame result not marked last");

    a_send_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND && out_free) |=> o_m_tvalid)
        else $error("result send did not load the output register");

endmodule

>>> rtl/serial_frame_receiver_crc16_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// s (rx)    in   i_s_tvalid/o_s_tready   i_s_tdata[7:0] = rx_byte
// m (res)   out  o_m_tvalid/i_m_tready   o_m_tdata, o_m_tuser = payload_present,
//                                        o_m_tlast = last_of_frame
// cfg       in   psel/penable/pwrite     paddr[3:2] = register, pwdata[7:0], prdata
//
// Header, payload and CRC bytes are taken one per cycle while the queue has room.
// A complete header adds a CRC pass over version..sequence, with o_s_tready low.
// Each result goes through a payload store read, then an output register load;
// draining one frame overlaps reception of the next through a four-request queue.
// Reset is synchronous; control state clears at once, no clearing pass is needed.
// A stalled output fills the queue, and then o_s_tready drops until it drains.

module serial_frame_receiver_crc16_core #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // receive byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] dest_address, [15:8] command_code, [23:16] sequence_number,
    // [29:24] payload_length, [37:30] payload_byte, [39:38] zero
    output logic [39:0] o_m_tdata,
    output logic        o_m_tuser,   // [0] payload_present
    output logic        o_m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_node;
    logic [7:0] r_bcast;
    logic [7:0] r_ver;

    logic            cfg_wr;
    logic            push;
    sfrc_pkg::t_qent push_ent;
    logic            q_full;
    logic            q_valid;
    sfrc_pkg::t_qent q_ent;
    logic            q_pop;

    // Configuration registers: write on the access phase, read back anytime
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node  <= 8'd1;
            r_bcast <= 8'd255;
            r_ver   <= 8'd1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                sfrc_pkg::REG_NODE:  r_node  <= pwdata[7:0];
                sfrc_pkg::REG_BCAST: r_bcast <= pwdata[7:0];
                sfrc_pkg::REG_VER:   r_ver   <= pwdata[7:0];
                default: begin
                    // unmapped: drop the write
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sfrc_pkg::REG_NODE:  prdata = {24'd0, r_node};
            sfrc_pkg::REG_BCAST: prdata = {24'd0, r_bcast};
            sfrc_pkg::REG_VER:   prdata = {24'd0, r_ver};
            default:             prdata = 32'd0;
        endcase
    end

    // Front: hunt for sync, collect header, check CRC, classify each byte
    sfrc_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_node  (r_node),
        .i_bcast (r_bcast),
        .i_ver   (r_ver),
        .i_full  (q_full),
        .o_push  (push),
        .o_ent   (push_ent)
    );

    // Queue: decouple parsing from frame emission
    sfrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_ent),
        .i_pop   (q_pop)
    );

    // Back: buffer payload, emit one result per byte of a committed frame (one if empty)
    sfrc_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_ent    (q_ent),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
